/* rtl/gcdec_pkg.sv */
package gcdec_pkg;

   // Curve sizing
   localparam int MAX_ENTRIES   = 1024;
   localparam int TOTAL_RESET   = 257;
   localparam int ENTRY_CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int ENTRY_IDX_W   = $clog2(MAX_ENTRIES);
   localparam int TOTAL_W       = 11;

   // Results per request: table start entry plus at most one per symbol
   localparam int SYMS_PER_BYTE = 4;
   localparam int MAX_RESULTS   = SYMS_PER_BYTE + 1;
   localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

   // Slope and level arithmetic
   localparam logic [7:0] FIRST_BOOST = 8'd8;

   // Symbol codes
   localparam logic [1:0] SYM_ZERO   = 2'd0;
   localparam logic [1:0] SYM_PLUS   = 2'd1;
   localparam logic [1:0] SYM_ESCAPE = 2'd2;
   localparam logic [1:0] SYM_MINUS  = 2'd3;

   // Position within an escape sequence
   typedef enum logic [1:0] {
      PHASE_OPCODE   = 2'd0,
      PHASE_ESC_LOW  = 2'd1,
      PHASE_ESC_HIGH = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       table_start;
   } gcdec_req_type;

   typedef struct packed {
      logic [15:0]            entry_value;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic                   run_last;
      logic                   table_done;
   } gcdec_rsp_type;

endpackage

/* rtl/gamma_curve_decoder_unit.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  gcdec_req_type (data_byte, table_start)
// rsp_      out        rsp_valid/rsp_stall  gcdec_rsp_type (value, index, last, done)
// csr_      in         csr_write_enable     csr_write_data = total_entries
//
// A request is registered, then decoded combinationally into zero to five entries
// that load a result buffer drained one entry per cycle, unless rsp_stall holds it,
// through its single output; a request reaches it via the input register.
// Synchronous reset empties both stages, sets total_entries to 257 and idles the
// decoder until a table start. A stalled output holds the buffer; the input
// register takes the next request in the cycle the buffer loads.
module gamma_curve_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gcdec_pkg::gcdec_req_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gcdec_pkg::gcdec_rsp_type      rsp_data,
   input  logic                          csr_write_enable,
   input  logic [gcdec_pkg::TOTAL_W-1:0] csr_write_data
);
   import gcdec_pkg::*;

   // Configuration
   logic [TOTAL_W-1:0]     total_ff;

   // Input register
   gcdec_req_type          req_ff;
   logic                   req_valid_ff;
   logic                   req_valid_in;

   // Decoder state
   phase_type              phase_ff, phase_in;
   logic [1:0]             esc_ff, esc_in;
   logic [7:0]             slope_ff, slope_in;
   logic [15:0]            level_ff, level_in;
   logic [ENTRY_CNT_W-1:0] emitted_ff, emitted_in;
   logic                   finished_ff, finished_in;

   // Result buffer
   gcdec_rsp_type          buf_ff [MAX_RESULTS];
   gcdec_rsp_type          buf_in [MAX_RESULTS];
   logic [RES_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RES_CNT_W-1:0]   rd_ptr_ff;

   logic                   take;
   logic                   drained;
   logic                   load;
   logic [ENTRY_CNT_W-1:0] eff_total;

   // Handshakes
   assign rsp_valid = (rd_ptr_ff != cnt_ff);
   assign rsp_data  = buf_ff[rd_ptr_ff];
   assign take      = rsp_valid && !rsp_stall;
   assign drained   = !rsp_valid || (take && (rd_ptr_ff + 1'b1 == cnt_ff));
   assign load      = req_valid_ff && drained;
   assign req_stall = req_valid_ff && !load;

   // Clamp the configured count to the supported range
   always_comb begin
      if (total_ff > TOTAL_W'(MAX_ENTRIES)) begin
         eff_total = ENTRY_CNT_W'(MAX_ENTRIES);
      end else if (total_ff == '0) begin
         eff_total = ENTRY_CNT_W'(1);
      end else begin
         eff_total = ENTRY_CNT_W'(total_ff);
      end
   end

   // Decode the registered request into its entries
   always_comb begin
      phase_type              ph;
      logic [1:0]             esc;
      logic [7:0]             sl;
      logic [15:0]            lv;
      logic [ENTRY_CNT_W-1:0] em;
      logic                   fin;
      logic [RES_CNT_W-1:0]   n;
      logic [1:0]             sym;
      logic [7:0]             delta;
      logic                   apply;
      logic                   done;

      ph    = phase_ff;
      esc   = esc_ff;
      sl    = slope_ff;
      lv    = level_ff;
      em    = emitted_ff;
      fin   = finished_ff;
      n     = '0;
      sym   = SYM_ZERO;
      delta = '0;
      apply = 1'b0;
      done  = 1'b0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         buf_in[i] = '0;
      end

      // Table start: clear state and emit the zero entry
      if (req_ff.table_start) begin
         done        = (eff_total <= ENTRY_CNT_W'(1));
         ph          = PHASE_OPCODE;
         esc         = '0;
         sl          = '0;
         lv          = '0;
         buf_in[0]   = '{entry_value: '0, entry_index: '0, run_last: 1'b0,
                         table_done: done};
         n           = RES_CNT_W'(1);
         em          = ENTRY_CNT_W'(1);
         fin         = done;
      end

      // Walk the four symbols, low pair first
      for (int s = 0; s < SYMS_PER_BYTE; s++) begin
         apply = 1'b0;
         delta = '0;
         if (!fin) begin
            sym = req_ff.data_byte[2*s +: 2];
            case (ph)
               PHASE_ESC_LOW: begin
                  esc = sym;
                  ph  = PHASE_ESC_HIGH;
               end
               PHASE_ESC_HIGH: begin
                  delta = {{4{sym[1]}}, sym, esc};
                  ph    = PHASE_OPCODE;
                  apply = 1'b1;
               end
               default: begin
                  if (sym == SYM_ESCAPE) begin
                     ph = PHASE_ESC_LOW;
                  end else begin
                     ph    = PHASE_OPCODE;
                     apply = 1'b1;
                     case (sym)
                        SYM_PLUS:  delta = 8'h01;
                        SYM_MINUS: delta = 8'hFF;
                        default:   delta = 8'h00;
                     endcase
                  end
               end
            endcase

            // Advance slope and level, emit one entry
            if (apply) begin
               if (em >= eff_total) begin
                  fin = 1'b1;
               end else begin
                  if (em == ENTRY_CNT_W'(1)) begin
                     delta = delta + FIRST_BOOST;
                  end
                  sl   = sl + delta;
                  lv   = lv + {8'h00, sl};
                  done = ((em + 1'b1) >= eff_total);
                  buf_in[n] = '{entry_value: lv, entry_index: em[ENTRY_IDX_W-1:0],
                                run_last: 1'b0, table_done: done};
                  em   = em + 1'b1;
                  n    = n + 1'b1;
                  if (done) begin
                     fin = 1'b1;
                  end
               end
            end
         end
      end

      // Mark the last entry of this request
      if (n != '0) begin
         buf_in[n - 1'b1].run_last = 1'b1;
      end

      phase_in    = ph;
      esc_in      = esc;
      slope_in    = sl;
      level_in    = lv;
      emitted_in  = em;
      finished_in = fin;
      cnt_in      = n;
   end

   // Input register valid
   always_comb begin
      if (req_valid && !req_stall) begin
         req_valid_in = 1'b1;
      end else if (load) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= TOTAL_W'(TOTAL_RESET);
         req_valid_ff <= 1'b0;
         phase_ff     <= PHASE_OPCODE;
         esc_ff       <= '0;
         slope_ff     <= '0;
         level_ff     <= '0;
         emitted_ff   <= '0;
         finished_ff  <= 1'b1;
         cnt_ff       <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            total_ff <= csr_write_data;
         end
         req_valid_ff <= req_valid_in;
         if (load) begin
            phase_ff    <= phase_in;
            esc_ff      <= esc_in;
            slope_ff    <= slope_in;
            level_ff    <= level_in;
            emitted_ff  <= emitted_in;
            finished_ff <= finished_in;
            cnt_ff      <= cnt_in;
            rd_ptr_ff   <= '0;
         end else if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_ff[i] <= buf_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   // Read pointer never passes the fill count
   assert property (@(posedge clock) disable iff (reset) rd_ptr_ff <= cnt_ff)
      else $error("result buffer read pointer beyond fill count");

   // Buffer loads only once its contents are gone
   assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid || (take && (rd_ptr_ff + 1'b1 == cnt_ff))))
      else $error("result buffer overwritten before drained");

   // Entry count stays within the supported table size
   assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= ENTRY_CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   // An entry marked table done is always the last entry of its request
   assert property (@(posedge clock) disable iff (reset)
      (take && rsp_data.table_done) |-> rsp_data.run_last)
      else $error("entries follow the final table entry within a request");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import gcdec_pkg::*;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 50;
   localparam int STREAM_ITEMS = 24;
   localparam int IDLE_PERCENT = 35;

   // Predicts curve entries from accepted requests and checks the entries that come out
   class curve_scoreboard;
      logic [TOTAL_W-1:0] tbl_total;
      phase_type          phase;
      logic [1:0]         esc_low;
      logic [7:0]         slope;
      logic [15:0]        level;
      int                 emitted;
      bit                 finished;
      gcdec_rsp_type      curve_q[$];
      int                 failures;

      function new();
         tbl_total = TOTAL_W'(TOTAL_RESET);
         phase     = PHASE_OPCODE;
         esc_low   = '0;
         slope     = '0;
         level     = '0;
         emitted   = 0;
         finished  = 1'b1;
         failures  = 0;
      endfunction

      function int pending();
         return curve_q.size();
      endfunction

      // Clamp the table length to what the block can hold
      function int eff_total();
         int t;
         t = tbl_total;
         if (t > MAX_ENTRIES)
            t = MAX_ENTRIES;
         if (t < 1)
            t = 1;
         return t;
      endfunction

      function void push_entry(logic [15:0] value, int idx, bit done);
         gcdec_rsp_type e;
         e.entry_value = value;
         e.entry_index = idx[ENTRY_IDX_W-1:0];
         e.run_last    = 1'b0;
         e.table_done  = done;
         curve_q.push_back(e);
      endfunction

      // Accumulate one slope delta into the level; stop once the table is full
      function void add_delta(logic [7:0] delta);
         bit done;
         if (emitted >= eff_total()) begin
            finished = 1'b1;
            return;
         end
         if (emitted == 1)
            delta = delta + 8'd8;
         slope = slope + delta;
         level = level + 16'(slope);
         done  = (emitted + 1) >= eff_total();
         push_entry(level, emitted, done);
         emitted++;
         if (done)
            finished = 1'b1;
      endfunction

      function void note_request(gcdec_req_type r);
         int         before_cnt;
         logic [1:0] sym;
         logic [3:0] esc_val;
         before_cnt = curve_q.size();
         // Table start clears the decoder and emits the zero entry
         if (r.table_start) begin
            phase    = PHASE_OPCODE;
            esc_low  = '0;
            slope    = '0;
            level    = '0;
            finished = eff_total() <= 1;
            push_entry(16'd0, 0, finished);
            emitted  = 1;
         end
         // Walk the symbols from the low bits upward
         for (int s = 0; s < SYMS_PER_BYTE && !finished; s++) begin
            sym = r.data_byte[2*s +: 2];
            case (phase)
               PHASE_ESC_LOW: begin
                  esc_low = sym;
                  phase   = PHASE_ESC_HIGH;
               end
               PHASE_ESC_HIGH: begin
                  esc_val = {sym, esc_low};
                  phase   = PHASE_OPCODE;
                  add_delta({{4{esc_val[3]}}, esc_val});
               end
               default: begin
                  if (sym == SYM_ESCAPE)
                     phase = PHASE_ESC_LOW;
                  else if (sym == SYM_ZERO)
                     add_delta(8'h00);
                  else if (sym == SYM_PLUS)
                     add_delta(8'h01);
                  else
                     add_delta(8'hFF);
               end
            endcase
         end
         // Flag the last entry of this request
         if (curve_q.size() > before_cnt)
            curve_q[curve_q.size()-1].run_last = 1'b1;
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10)
            $display("ERROR: %s", msg);
      endfunction

      function void check_entry(gcdec_rsp_type got);
         gcdec_rsp_type want;
         if (curve_q.size() == 0) begin
            note_failure($sformatf("unexpected entry value %h index %0d last %b done %b",
                                   got.entry_value, got.entry_index, got.run_last,
                                   got.table_done));
            return;
         end
         want = curve_q.pop_front();
         if (got.entry_value !== want.entry_value || got.entry_index !== want.entry_index ||
             got.run_last !== want.run_last || got.table_done !== want.table_done)
            note_failure($sformatf({"entry mismatch: expected value %h index %0d last %b ",
                                    "done %b, got value %h index %0d last %b done %b"},
                                   want.entry_value, want.entry_index, want.run_last,
                                   want.table_done, got.entry_value, got.entry_index,
                                   got.run_last, got.table_done));
      endfunction

      // Anything still queued at the end never arrived
      function void close_out();
         while (curve_q.size() != 0) begin
            gcdec_rsp_type want;
            want = curve_q.pop_front();
            note_failure($sformatf("missing entry value %h index %0d",
                                   want.entry_value, want.entry_index));
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   gcdec_req_type      req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   gcdec_rsp_type      rsp_data;
   logic               csr_write_enable;
   logic [TOTAL_W-1:0] csr_write_data;

   curve_scoreboard sb = new();
   bit              steady;
   int              cycle_count;

   gamma_curve_decoder_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Check entries as they drain and stall the output at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_entry(rsp_data);
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   task automatic send_request(logic [7:0] data_byte, logic table_start);
      gcdec_req_type r;
      r.data_byte   = data_byte;
      r.table_start = table_start;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(r);
   endtask

   // Hold off until every predicted entry is out, then let the pipeline empty
   task automatic settle_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_total(logic [TOTAL_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.tbl_total = value;
      @(posedge clock);
   endtask

   function automatic logic [TOTAL_W-1:0] pick_total();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return TOTAL_W'($urandom_range(0, 1));
      else if (r == 1)
         return TOTAL_W'($urandom_range(MAX_ENTRIES + 1, 2047));
      else if (r == 2)
         return TOTAL_W'($urandom_range(41, MAX_ENTRIES));
      return TOTAL_W'($urandom_range(2, 40));
   endfunction

   initial begin
      int         counted;
      int         phase_len;
      int         phase_num;
      int         n;
      bit         start;
      logic [7:0] data_byte;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      steady           = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default length: idle byte, plain symbols, escapes across bytes, restart
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b1);
      send_request(8'h55, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hE6, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h0F, 1'b0);
      send_request(8'h60, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'h22, 1'b0);
      send_request(8'h1E, 1'b0);
      send_request(8'hAA, 1'b1);
      settle_block();

      // Tiny tables: only the zero entry, later bytes ignored
      write_total(TOTAL_W'(1));
      send_request(8'h55, 1'b1);
      send_request(8'h55, 1'b0);
      settle_block();
      write_total(TOTAL_W'(0));
      send_request(8'hFF, 1'b1);
      settle_block();

      // Two entries, trailing escape dropped
      write_total(TOTAL_W'(2));
      send_request(8'h82, 1'b1);
      settle_block();

      // Grow the table mid-way
      write_total(TOTAL_W'(8));
      send_request(8'h00, 1'b1);
      settle_block();
      write_total(TOTAL_W'(9));
      send_request(8'h55, 1'b0);
      settle_block();

      // Shrink below what is already out: decoding stops silently
      write_total(TOTAL_W'(6));
      send_request(8'h00, 1'b1);
      settle_block();
      write_total(TOTAL_W'(3));
      send_request(8'h55, 1'b0);
      settle_block();

      // Unbroken stream at the saturated count, slope and level wrapping below zero
      steady = 1'b1;
      write_total(TOTAL_W'(2047));
      send_request(8'hFF, 1'b1);
      for (n = 0; n < STREAM_ITEMS; n++)
         send_request(n < 8 ? 8'hFF : 8'($urandom_range(0, 255)), 1'b0);
      settle_block();

      // Random tables under changing lengths
      counted   = 0;
      phase_num = 0;
      while (counted < RANDOM_ITEMS) begin
         steady = (phase_num == 0);
         write_total(phase_num == 0 ? TOTAL_W'(MAX_ENTRIES) : pick_total());
         phase_len = $urandom_range(6, 24);
         repeat (phase_len) begin
            if (sb.finished)
               start = $urandom_range(0, 9) != 0;
            else
               start = $urandom_range(0, 19) == 0;
            if (start || !sb.finished)
               counted++;
            data_byte = 8'($urandom_range(0, 255));
            send_request(data_byte, start);
            if ($urandom_range(0, 24) == 0)
               settle_block();
         end
         settle_block();
         phase_num++;
      end

      steady = 1'b0;
      settle_block();
      sb.close_out();
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* files.f */
rtl/gcdec_pkg.sv
rtl/gamma_curve_decoder_unit.sv
sim/tb.sv
